FILE: hw/rtl/input_event_to_evdev_serializer_defines.svh
// Assertion macros shared by the serializer RTL
`ifndef INPUT_EVENT_TO_EVDEV_SERIALIZER_DEFINES_SVH
`define INPUT_EVENT_TO_EVDEV_SERIALIZER_DEFINES_SVH

// Property checked on every clock edge outside reset
`define IEVS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define IEVS_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/ievs_pkg.sv
// Types and constants of the input event serializer
`default_nettype none

package ievs_pkg;

   localparam logic [7:0] EXT_PREFIX_CODE = 8'hE0;
   localparam logic [7:0] RELEASE_MASK    = 8'h80;
   localparam logic [7:0] KEY_INDEX_MASK  = 8'h7F;

   localparam int TYPE_W  = 5;
   localparam int CODE_W  = 10;
   localparam int VALUE_W = 32;

   localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
   localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
   localparam logic [TYPE_W-1:0] EV_REL = 5'd2;

   localparam logic [CODE_W-1:0] REL_X             = 10'd0;
   localparam logic [CODE_W-1:0] REL_Y             = 10'd1;
   localparam logic [CODE_W-1:0] REL_Z             = 10'd2;
   localparam logic [CODE_W-1:0] MOUSE_LEFT_CODE   = 10'h110;
   localparam logic [CODE_W-1:0] MOUSE_RIGHT_CODE  = 10'h111;
   localparam logic [CODE_W-1:0] MOUSE_MIDDLE_CODE = 10'h112;

   localparam int BIT_LEFT   = 0;
   localparam int BIT_RIGHT  = 1;
   localparam int BIT_MIDDLE = 2;

   localparam logic OPC_KEY   = 1'b0;
   localparam logic OPC_MOUSE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                      is_mouse;
      logic [7:0]                key_code;
      logic                      key_level;
      logic signed [VALUE_W-1:0] delta_x;
      logic signed [VALUE_W-1:0] delta_y;
      logic signed [VALUE_W-1:0] delta_wheel;
      logic [2:0]                change;
      logic [2:0]                levels;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FIRST,
      ST_REL_Y,
      ST_REL_Z,
      ST_LEFT_KEY,
      ST_MIDDLE_KEY,
      ST_RIGHT_KEY,
      ST_SYNC
   } step_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ievs_front.sv
// Front end: accepts items, tracks prefix and button state, builds commands
`default_nettype none
`include "input_event_to_evdev_serializer_defines.svh"

module ievs_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic [7:0]                         req_scancode,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_x,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_y,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_wheel,
   input  wire logic [2:0]                         req_button_levels,
   input  wire logic                               queue_full,
   output logic                                    push_valid,
   output ievs_pkg::cmd_type                       push_cmd
);
   import ievs_pkg::*;

   logic       extended_pending_ff, extended_pending_in;
   logic [2:0] held_buttons_ff, held_buttons_in;
   logic       accept;
   logic       is_prefix;

   always_comb begin
      req_ready = !queue_full;
      accept    = req_valid && req_ready;
      is_prefix = (req_opcode == OPC_KEY) && (req_scancode == EXT_PREFIX_CODE);
      push_valid = accept && !is_prefix;

      push_cmd.is_mouse    = (req_opcode == OPC_MOUSE);
      push_cmd.key_code    = (req_scancode & KEY_INDEX_MASK)
                             | {extended_pending_ff, 7'd0};
      push_cmd.key_level   = ((req_scancode & RELEASE_MASK) == 8'd0);
      push_cmd.delta_x     = req_delta_x;
      push_cmd.delta_y     = req_delta_y;
      push_cmd.delta_wheel = req_delta_wheel;
      push_cmd.change      = held_buttons_ff ^ req_button_levels;
      push_cmd.levels      = req_button_levels;
   end

   always_comb begin
      extended_pending_in = extended_pending_ff;
      held_buttons_in     = held_buttons_ff;
      if (accept) begin
         if (req_opcode == OPC_KEY) begin
            extended_pending_in = is_prefix;
         end else begin
            held_buttons_in = req_button_levels;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extended_pending_ff <= 1'b0;
         held_buttons_ff     <= 3'd0;
      end else begin
         extended_pending_ff <= extended_pending_in;
         held_buttons_ff     <= held_buttons_in;
      end
   end

   `IEVS_ASSERT(a_prefix_arms, (accept && is_prefix) |=> extended_pending_ff, "prefix not armed")

endmodule

`default_nettype wire

FILE: hw/rtl/ievs_queue.sv
// Short command queue between front and back end
`default_nettype none
`include "input_event_to_evdev_serializer_defines.svh"

module ievs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire ievs_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output ievs_pkg::cmd_type      head_cmd
);
   import ievs_pkg::*;

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full       = (count_ff == CNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `IEVS_NEVER(a_push_full, push_valid && full, "push into full queue")
   `IEVS_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: hw/rtl/ievs_back.sv
// Back end: expands one command into its event run through an output register
`default_nettype none
`include "input_event_to_evdev_serializer_defines.svh"

module ievs_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                head_valid,
   input  wire ievs_pkg::cmd_type                   head_cmd,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ievs_pkg::TYPE_W-1:0]              rsp_event_type,
   output logic [ievs_pkg::CODE_W-1:0]              rsp_event_code,
   output logic signed [ievs_pkg::VALUE_W-1:0]      rsp_event_value,
   output logic                                     rsp_last_of_run
);
   import ievs_pkg::*;

   step_type                  state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]         type_ff, type_in;
   logic [CODE_W-1:0]         code_ff, code_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      last_ff, last_in;
   logic                      advance;
   logic                      fire;

   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      fire    = advance && head_valid;
      pop     = fire && (state_ff == ST_SYNC);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (fire) begin
         case (state_ff)
            ST_FIRST:      state_in = head_cmd.is_mouse ? ST_REL_Y : ST_SYNC;
            ST_REL_Y:      state_in = ST_REL_Z;
            ST_REL_Z: begin
               if (head_cmd.change[BIT_LEFT]) begin
                  state_in = ST_LEFT_KEY;
               end else if (head_cmd.change[BIT_MIDDLE]) begin
                  state_in = ST_MIDDLE_KEY;
               end else if (head_cmd.change[BIT_RIGHT]) begin
                  state_in = ST_RIGHT_KEY;
               end else begin
                  state_in = ST_SYNC;
               end
            end
            ST_LEFT_KEY: begin
               if (head_cmd.change[BIT_MIDDLE]) begin
                  state_in = ST_MIDDLE_KEY;
               end else if (head_cmd.change[BIT_RIGHT]) begin
                  state_in = ST_RIGHT_KEY;
               end else begin
                  state_in = ST_SYNC;
               end
            end
            ST_MIDDLE_KEY: state_in = head_cmd.change[BIT_RIGHT] ? ST_RIGHT_KEY : ST_SYNC;
            ST_RIGHT_KEY:  state_in = ST_SYNC;
            ST_SYNC:       state_in = ST_FIRST;
            default:       state_in = ST_FIRST;
         endcase
      end
   end

   // event for the current step
   always_comb begin
      type_in  = EV_SYN;
      code_in  = '0;
      value_in = '0;
      last_in  = 1'b0;
      case (state_ff)
         ST_FIRST: begin
            if (head_cmd.is_mouse) begin
               type_in  = EV_REL;
               code_in  = REL_X;
               value_in = head_cmd.delta_x;
            end else begin
               type_in  = EV_KEY;
               code_in  = {2'b00, head_cmd.key_code};
               value_in = {31'd0, head_cmd.key_level};
            end
         end
         ST_REL_Y: begin
            type_in  = EV_REL;
            code_in  = REL_Y;
            value_in = head_cmd.delta_y;
         end
         ST_REL_Z: begin
            type_in  = EV_REL;
            code_in  = REL_Z;
            value_in = head_cmd.delta_wheel;
         end
         ST_LEFT_KEY: begin
            type_in  = EV_KEY;
            code_in  = MOUSE_LEFT_CODE;
            value_in = {31'd0, head_cmd.levels[BIT_LEFT]};
         end
         ST_MIDDLE_KEY: begin
            type_in  = EV_KEY;
            code_in  = MOUSE_MIDDLE_CODE;
            value_in = {31'd0, head_cmd.levels[BIT_MIDDLE]};
         end
         ST_RIGHT_KEY: begin
            type_in  = EV_KEY;
            code_in  = MOUSE_RIGHT_CODE;
            value_in = {31'd0, head_cmd.levels[BIT_RIGHT]};
         end
         ST_SYNC: begin
            last_in = 1'b1;
         end
         default: begin
            type_in = EV_SYN;
         end
      endcase
      rsp_valid_in = advance ? head_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         type_ff  <= type_in;
         code_ff  <= code_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_type  = type_ff;
   assign rsp_event_code  = code_ff;
   assign rsp_event_value = value_ff;
   assign rsp_last_of_run = last_ff;

   `IEVS_ASSERT(a_last_is_sync, (rsp_valid_ff && last_ff) |-> (type_ff == EV_SYN), "last not sync")
   `IEVS_ASSERT(a_run_restarts, pop |=> (state_ff == ST_FIRST), "run did not restart")

endmodule

`default_nettype wire

FILE: hw/rtl/input_event_to_evdev_serializer.sv
// Input event serializer: keyboard scancodes and mouse reports to evdev events
//
// Input channel (req_*): one keyboard scancode or mouse report per transfer.
// Output channel (rsp_*): one evdev event (type, code, value) per transfer;
// rsp_last_of_run marks the closing sync event of each run.
// A key item gives two events (key, sync); a 0xE0 prefix gives none and only
// offsets the next key code by 128. A mouse item gives relative X, Y, wheel,
// one key event per changed button (left, middle, right), then sync: 4 to 7.
// The first event of an item passes the command queue and then the output
// register on its way to rsp. Throughput: one event per cycle while rsp_ready
// is high and a command is queued, set by the single output register.
// A two-entry command queue sits between the front end and the event
// sequencer, so new items are taken while an earlier run is still emitted.
// When the receiver stalls, the output register holds its event, the queue
// fills, and req_ready drops once both entries are in use.
// Reset (synchronous) clears the pending prefix, the held button levels,
// the queue, the sequencer state and the valid flag of the output register.
`default_nettype none

module input_event_to_evdev_serializer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [7:0]                          req_scancode,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_x,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_y,
   input  wire logic signed [ievs_pkg::VALUE_W-1:0] req_delta_wheel,
   input  wire logic [2:0]                          req_button_levels,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ievs_pkg::TYPE_W-1:0]              rsp_event_type,
   output logic [ievs_pkg::CODE_W-1:0]              rsp_event_code,
   output logic signed [ievs_pkg::VALUE_W-1:0]      rsp_event_value,
   output logic                                     rsp_last_of_run
);
   import ievs_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   ievs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_scancode      (req_scancode),
      .req_delta_x       (req_delta_x),
      .req_delta_y       (req_delta_y),
      .req_delta_wheel   (req_delta_wheel),
      .req_button_levels (req_button_levels),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_cmd          (push_cmd)
   );

   ievs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ievs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_type  (rsp_event_type),
      .rsp_event_code  (rsp_event_code),
      .rsp_event_value (rsp_event_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: verif/input_event_to_evdev_serializer_test.sv
// Self-checking testbench for the scancode and mouse report to evdev event serializer
`timescale 1ns / 1ps

module input_event_to_evdev_serializer_test;
   import ievs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 310;

   typedef struct {
      logic [TYPE_W-1:0]  ev_type;
      logic [CODE_W-1:0]  ev_code;
      logic [VALUE_W-1:0] ev_value;
      logic               last;
   } evdev_event_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = OPC_KEY;
   logic [7:0]                req_scancode = '0;
   logic signed [VALUE_W-1:0] req_delta_x = '0;
   logic signed [VALUE_W-1:0] req_delta_y = '0;
   logic signed [VALUE_W-1:0] req_delta_wheel = '0;
   logic [2:0]                req_button_levels = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [TYPE_W-1:0]         rsp_event_type;
   logic [CODE_W-1:0]         rsp_event_code;
   logic signed [VALUE_W-1:0] rsp_event_value;
   logic                      rsp_last_of_run;

   evdev_event_type expected_events[$];
   logic            ext_prefix_armed = 1'b0;
   logic [2:0]      held_levels = '0;
   int              mismatches = 0;
   int              cycles = 0;
   bit              sender_gaps = 1'b0;
   int              burst_left = 0;
   bit              receiver_stalls = 1'b0;
   int              stall_left = 0;
   int              ready_left = 0;

   input_event_to_evdev_serializer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_scancode      (req_scancode),
      .req_delta_x       (req_delta_x),
      .req_delta_y       (req_delta_y),
      .req_delta_wheel   (req_delta_wheel),
      .req_button_levels (req_button_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_type    (rsp_event_type),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_value   (rsp_event_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("input_event_to_evdev_serializer regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      mismatches++;
   endtask

   task automatic push_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                             input logic [VALUE_W-1:0] v, input logic l);
      evdev_event_type e;
      e.ev_type  = t;
      e.ev_code  = c;
      e.ev_value = v;
      e.last     = l;
      expected_events.push_back(e);
   endtask

   // Expected event run for one accepted item; updates prefix and button state
   task automatic expand_to_events(input logic opc, input logic [7:0] sc,
                                   input logic [31:0] dx, input logic [31:0] dy,
                                   input logic [31:0] dz, input logic [2:0] levels);
      logic [CODE_W-1:0] key;
      logic [2:0]        change;
      if (opc == OPC_KEY) begin
         if (sc == EXT_PREFIX_CODE) begin
            ext_prefix_armed = 1'b1;
         end else begin
            key = CODE_W'(sc & KEY_INDEX_MASK) + (ext_prefix_armed ? CODE_W'(128) : '0);
            ext_prefix_armed = 1'b0;
            push_event(EV_KEY, key, ((sc & RELEASE_MASK) != 0) ? 32'd0 : 32'd1, 1'b0);
            push_event(EV_SYN, '0, '0, 1'b1);
         end
      end else begin
         change = held_levels ^ levels;
         push_event(EV_REL, REL_X, dx, 1'b0);
         push_event(EV_REL, REL_Y, dy, 1'b0);
         push_event(EV_REL, REL_Z, dz, 1'b0);
         if (change[BIT_LEFT])
            push_event(EV_KEY, MOUSE_LEFT_CODE, 32'(levels[BIT_LEFT]), 1'b0);
         if (change[BIT_MIDDLE])
            push_event(EV_KEY, MOUSE_MIDDLE_CODE, 32'(levels[BIT_MIDDLE]), 1'b0);
         if (change[BIT_RIGHT])
            push_event(EV_KEY, MOUSE_RIGHT_CODE, 32'(levels[BIT_RIGHT]), 1'b0);
         held_levels = levels;
         push_event(EV_SYN, '0, '0, 1'b1);
      end
   endtask

   task automatic send_item(input logic opc, input logic [7:0] sc,
                            input logic [31:0] dx, input logic [31:0] dy,
                            input logic [31:0] dz, input logic [2:0] levels);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= opc;
      req_scancode      <= sc;
      req_delta_x       <= dx;
      req_delta_y       <= dy;
      req_delta_wheel   <= dz;
      req_button_levels <= levels;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expand_to_events(opc, sc, dx, dy, dz, levels);
   endtask

   task automatic send_key(input logic [7:0] sc);
      send_item(OPC_KEY, sc, $urandom, $urandom, $urandom, 3'($urandom));
   endtask

   task automatic send_mouse(input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] dz, input logic [2:0] levels);
      send_item(OPC_MOUSE, 8'($urandom), dx, dy, dz, levels);
   endtask

   // Receiver: ready runs and stall runs of random length
   initial begin
      forever begin
         @(negedge clock);
         if (!receiver_stalls) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (ready_left > 0) begin
            ready_left--;
            rsp_ready <= 1'b1;
         end else begin
            stall_left = $urandom_range(0, 7);
            ready_left = $urandom_range(1, 6);
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("event with none expected, code", 32'(rsp_event_code), '0);
         end else begin
            if (rsp_event_type !== expected_events[0].ev_type)
               report_mismatch("event_type", 32'(rsp_event_type), 32'(expected_events[0].ev_type));
            if (rsp_event_code !== expected_events[0].ev_code)
               report_mismatch("event_code", 32'(rsp_event_code), 32'(expected_events[0].ev_code));
            if (rsp_event_value !== expected_events[0].ev_value)
               report_mismatch("event_value", rsp_event_value, expected_events[0].ev_value);
            if (rsp_last_of_run !== expected_events[0].last)
               report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(expected_events[0].last));
            void'(expected_events.pop_front());
         end
      end
   end

   task automatic test_key_extremes;
      send_key(8'h00);
      send_key(8'h7F);
      send_key(8'h80);
      send_key(8'hFF);
      send_key(8'h81);
   endtask

   task automatic test_extended_prefix;
      send_key(EXT_PREFIX_CODE);
      send_key(8'h48);
      send_key(EXT_PREFIX_CODE);
      send_key(EXT_PREFIX_CODE);
      send_key(8'hC8);
      send_key(EXT_PREFIX_CODE);
      // mouse report between prefix and key keeps the prefix armed
      send_mouse(32'd5, 32'd6, 32'd7, 3'b000);
      send_key(8'h7F);
      send_key(EXT_PREFIX_CODE);
      send_key(8'hFF);
   endtask

   task automatic test_mouse_buttons;
      send_item(OPC_MOUSE, EXT_PREFIX_CODE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 3'b111);
      send_mouse(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'b111);
      send_mouse(32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 3'b000);
      send_mouse(32'h0, 32'h0, 32'h8000_0000, 3'b001);
      send_mouse(32'hAAAA_5555, 32'h5555_AAAA, 32'h0, 3'b100);
      send_mouse(32'h0, 32'h0, 32'h0, 3'b010);
      send_mouse(32'h0, 32'h0, 32'h0, 3'b000);
      send_key(8'h1E);
   endtask

   function automatic logic [31:0] pick_delta();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_traffic;
      int       sent;
      int       pick;
      logic [2:0] levels;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ((sent * 4) / RANDOM_ITEMS)
            0: begin sender_gaps = 1'b1; receiver_stalls = 1'b1; end
            1: begin sender_gaps = 1'b0; receiver_stalls = 1'b0; end
            2: begin sender_gaps = 1'b0; receiver_stalls = 1'b1; end
            default: begin sender_gaps = 1'b1; receiver_stalls = 1'b0; end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_key(8'($urandom));
            sent++;
         end else if (pick < 50) begin
            send_key(EXT_PREFIX_CODE);
            send_key(8'($urandom));
            sent += 2;
         end else begin
            levels = ($urandom_range(0, 3) == 0) ? held_levels : 3'($urandom);
            send_mouse(pick_delta(), pick_delta(), pick_delta(), levels);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_key_extremes();
      test_extended_prefix();
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      test_mouse_buttons();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("input_event_to_evdev_serializer regression: pass");
      else
         $display("input_event_to_evdev_serializer regression: fail");
      $finish;
   end

endmodule
